// ----- design/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg - point projection shared definitions
// Widths, register codes, the configuration bundle and the words that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int COORD_W   = 21;
    localparam int DIFF_W    = 22;
    localparam int AXIS_W    = 16;
    localparam int AXIS_FRAC = 14;
    localparam int PROD_W    = 38;
    localparam int DOT_W     = 40;
    localparam int PART_W    = 40;
    localparam int NUM_W     = 61;
    localparam int DEN_W     = 46;
    localparam int Q_W       = 13;
    localparam int PIXX_W    = 13;
    localparam int PIXY_W    = 12;
    localparam int DEPTH_W   = 20;
    localparam int FOCAL_W   = 16;
    localparam int PANEL_W   = 13;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_COORD_FRAC_BITS  = 10;
    localparam int DEF_MAX_PANEL_PIXELS = 4096;

    localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 16'd8868;
    localparam logic [PANEL_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [PANEL_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EYE    = 3'd0,
        CFG_FWD    = 3'd1,
        CFG_RIGHT  = 3'd2,
        CFG_UP     = 3'd3,
        CFG_FOCAL  = 3'd4,
        CFG_WIDTH  = 3'd5,
        CFG_HEIGHT = 3'd6,
        CFG_LEFT   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [3*COORD_W-1:0] eye;
        logic [3*AXIS_W-1:0]  fwd;
        logic [3*AXIS_W-1:0]  right;
        logic [3*AXIS_W-1:0]  up;
        logic [FOCAL_W-1:0]   focal;
        logic [PANEL_W-1:0]   width;
        logic [PANEL_W-1:0]   height;
        logic [PANEL_W-1:0]   left;
    } cfg_t;

    typedef struct packed {
        logic                    near_ok;
        logic signed [DOT_W-1:0] cz;
        logic signed [DOT_W-1:0] xl;
        logic signed [DOT_W-1:0] yl;
    } front_word_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic               push;
        logic               pop;
    } queue_ctl_t;

    function automatic logic signed [AXIS_W-1:0] axis_comp(
        input logic [3*AXIS_W-1:0] a,
        input int                  i
    );
        return $signed(a[AXIS_W*i +: AXIS_W]);
    endfunction

endpackage

// ----- design/ppp_ifs.sv -----
// ----------------------------------------------------------------------------
// ppp_ifs - point and pixel stream channels
// Valid/ready channels for the input point words and the result words.
// ----------------------------------------------------------------------------
interface ppp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ppp_pkg::COORD_W-1:0]   point_x;
    logic signed [ppp_pkg::COORD_W-1:0]   point_y;
    logic signed [ppp_pkg::COORD_W-1:0]   point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface ppp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 visible;
    logic [ppp_pkg::PIXX_W-1:0]           pixel_x;
    logic [ppp_pkg::PIXY_W-1:0]           pixel_y;
    logic [ppp_pkg::DEPTH_W-1:0]          depth_value;

    modport source (output valid, output visible, output pixel_x, output pixel_y,
                    output depth_value, input ready);
    modport sink   (input valid, input visible, input pixel_x, input pixel_y,
                    input depth_value, output ready);
endinterface

// ----- design/point_perspective_projection.sv -----
// ----------------------------------------------------------------------------
// point_perspective_projection - pinhole projection of world points
// Projects one world point per word through a fixed view camera and culls
// it against the panel.
// ----------------------------------------------------------------------------
// Takes one point per clock cycle while the output is taken. A result word
// passes three front stages for eye offset and dot products, the four-entry
// queue, five scaling stages, a range check and a thirteen-stage restoring
// divider that resolves one pixel bit per stage for both coordinates, then
// the output register.
// Camera registers must be written only while no point is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module point_perspective_projection #(
    parameter int COORD_FRAC_BITS  = ppp_pkg::DEF_COORD_FRAC_BITS,
    parameter int MAX_PANEL_PIXELS = ppp_pkg::DEF_MAX_PANEL_PIXELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ppp_in_if.sink                          in_word,
    ppp_out_if.source                       out_word,
    input  logic                            cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]       cfg_data
);

    ppp_pkg::cfg_t          cfg_reg;
    ppp_pkg::front_word_t   push_word, pop_word;
    ppp_pkg::queue_ctl_t    qctl;
    logic                   push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eye    <= '0;
            cfg_reg.fwd    <= '0;
            cfg_reg.right  <= '0;
            cfg_reg.up     <= '0;
            cfg_reg.focal  <= ppp_pkg::FOCAL_RESET;
            cfg_reg.width  <= ppp_pkg::WIDTH_RESET;
            cfg_reg.height <= ppp_pkg::HEIGHT_RESET;
            cfg_reg.left   <= '0;
        end
        else if (cfg_we)
        begin
            case (ppp_pkg::cfg_idx_t'(cfg_index))
                ppp_pkg::CFG_EYE:    cfg_reg.eye    <= cfg_data;
                ppp_pkg::CFG_FWD:    cfg_reg.fwd    <= cfg_data[3*ppp_pkg::AXIS_W-1:0];
                ppp_pkg::CFG_RIGHT:  cfg_reg.right  <= cfg_data[3*ppp_pkg::AXIS_W-1:0];
                ppp_pkg::CFG_UP:     cfg_reg.up     <= cfg_data[3*ppp_pkg::AXIS_W-1:0];
                ppp_pkg::CFG_FOCAL:  cfg_reg.focal  <= cfg_data[ppp_pkg::FOCAL_W-1:0];
                ppp_pkg::CFG_WIDTH:  cfg_reg.width  <= cfg_data[ppp_pkg::PANEL_W-1:0];
                ppp_pkg::CFG_HEIGHT: cfg_reg.height <= cfg_data[ppp_pkg::PANEL_W-1:0];
                ppp_pkg::CFG_LEFT:   cfg_reg.left   <= cfg_data[ppp_pkg::PANEL_W-1:0];
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    ppp_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_word    (in_word),
        .cfg        (cfg_reg),
        .queue_full (qctl.full),
        .push       (push),
        .push_word  (push_word)
    );

    ppp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .ctl       (qctl)
    );

    ppp_back #(
        .MAX_PANEL_PIXELS (MAX_PANEL_PIXELS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .qctl     (qctl),
        .pop_word (pop_word),
        .pop      (pop),
        .out_word (out_word)
    );

endmodule

// ----- design/ppp_front.sv -----
// ----------------------------------------------------------------------------
// ppp_front - eye subtraction, camera dot products and near-plane test
// Three stages: offset from the eye, nine products, three sums plus the
// near-plane classification. Stalls only when its last word meets a full queue.
// ----------------------------------------------------------------------------
module ppp_front #(
    parameter int COORD_FRAC_BITS = ppp_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ppp_in_if.sink                in_word,
    input  ppp_pkg::cfg_t         cfg,
    input  logic                  queue_full,
    output logic                  push,
    output ppp_pkg::front_word_t  push_word
);

    localparam longint NEAR_RAW =
        ((64'sd1 <<< (COORD_FRAC_BITS + ppp_pkg::AXIS_FRAC)) + 64'sd99) / 64'sd100;
    localparam logic signed [ppp_pkg::DOT_W-1:0] NEAR_MIN_CZ =
        ppp_pkg::DOT_W'(NEAR_RAW);

    logic                                 en;
    logic                                 v0_reg, v1_reg, v2_reg;
    logic signed [ppp_pkg::DIFF_W-1:0]    d_reg [3];
    logic signed [ppp_pkg::DIFF_W-1:0]    d_next [3];
    logic signed [ppp_pkg::PROD_W-1:0]    p_reg [9];
    logic signed [ppp_pkg::PROD_W-1:0]    p_next [9];
    ppp_pkg::front_word_t                 w_reg, w_next;

    function automatic logic signed [ppp_pkg::DIFF_W-1:0] DIFF_W_EXT(
        input logic signed [ppp_pkg::COORD_W-1:0] v
    );
        return ppp_pkg::DIFF_W'(v);
    endfunction

    assign en            = !(v2_reg && queue_full);
    assign in_word.ready = en;
    assign push          = v2_reg && !queue_full;
    assign push_word     = w_reg;

    always_comb
    begin
        d_next[0] = DIFF_W_EXT(in_word.point_x) - DIFF_W_EXT($signed(cfg.eye[20:0]));
        d_next[1] = DIFF_W_EXT(in_word.point_y) - DIFF_W_EXT($signed(cfg.eye[41:21]));
        d_next[2] = DIFF_W_EXT(in_word.point_z) - DIFF_W_EXT($signed(cfg.eye[62:42]));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i]     = ppp_pkg::PROD_W'(d_reg[i] * ppp_pkg::axis_comp(cfg.fwd, i));
            p_next[i + 3] = ppp_pkg::PROD_W'(d_reg[i] * ppp_pkg::axis_comp(cfg.right, i));
            p_next[i + 6] = ppp_pkg::PROD_W'(d_reg[i] * ppp_pkg::axis_comp(cfg.up, i));
        end
    end

    always_comb
    begin
        w_next.cz = ppp_pkg::DOT_W'(p_reg[0]) + ppp_pkg::DOT_W'(p_reg[1])
                  + ppp_pkg::DOT_W'(p_reg[2]);
        w_next.xl = ppp_pkg::DOT_W'(p_reg[3]) + ppp_pkg::DOT_W'(p_reg[4])
                  + ppp_pkg::DOT_W'(p_reg[5]);
        w_next.yl = ppp_pkg::DOT_W'(p_reg[6]) + ppp_pkg::DOT_W'(p_reg[7])
                  + ppp_pkg::DOT_W'(p_reg[8]);
        w_next.near_ok = (w_next.cz >= NEAR_MIN_CZ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_word.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            p_reg <= p_next;
            w_reg <= w_next;
        end
    end

endmodule

// ----- design/ppp_queue.sv -----
// ----------------------------------------------------------------------------
// ppp_queue - short queue between front and back end
// Four-entry register queue holding camera-space words.
// ----------------------------------------------------------------------------
module ppp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ppp_pkg::front_word_t  push_word,
    input  logic                  pop,
    output ppp_pkg::front_word_t  pop_word,
    output ppp_pkg::queue_ctl_t   ctl
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    ppp_pkg::front_word_t   mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]         count_reg, count_next;

    assign ctl.empty = (count_reg == '0);
    assign ctl.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign ctl.push  = push;
    assign ctl.pop   = pop;
    assign pop_word  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ----- design/ppp_back.sv -----
// ----------------------------------------------------------------------------
// ppp_back - perspective scaling, pipelined division and panel culling
// Partial products, numerator assembly, magnitudes, range check, thirteen
// restoring division steps and the final cull into the output register.
// ----------------------------------------------------------------------------
module ppp_back #(
    parameter int MAX_PANEL_PIXELS = ppp_pkg::DEF_MAX_PANEL_PIXELS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppp_pkg::cfg_t         cfg,
    input  ppp_pkg::queue_ctl_t   qctl,
    input  ppp_pkg::front_word_t  pop_word,
    output logic                  pop,
    ppp_out_if.source             out_word
);

    localparam int PW    = $clog2(MAX_PANEL_PIXELS + 1);
    localparam int CW    = PW + 2;
    localparam int STEPS = ppp_pkg::Q_W;
    localparam int NW    = ppp_pkg::NUM_W;
    localparam int XW    = ((CW > ppp_pkg::Q_W) ? CW : ppp_pkg::Q_W) + 1;

    typedef struct packed {
        logic                           near_ok;
        logic [ppp_pkg::DEPTH_W-1:0]    dv;
        logic [ppp_pkg::DEN_W-1:0]      den;
        logic                           sx, sy;
        logic                           ovx, ovy;
        logic [NW-1:0]                  rx, ry;
        logic [ppp_pkg::Q_W-1:0]        qx, qy;
    } div_t;

    logic                 en;
    logic [PW-1:0]        w_s, h_s, l_s;
    logic [CW-1:0]        c_s;

    logic                           v_reg [5];
    ppp_pkg::front_word_t           s0_reg;

    logic                           s1_near_reg;
    logic [ppp_pkg::DEPTH_W-1:0]    s1_dv_reg, s1_dv_next;
    logic [ppp_pkg::DOT_W-1:0]      s1_cz_reg;
    logic [ppp_pkg::PART_W-1:0]     ccl_reg, cch_reg, hcl_reg, hch_reg;
    logic signed [ppp_pkg::PART_W-1:0] fxl_reg, fxh_reg, fyl_reg, fyh_reg;

    logic                           s2_near_reg;
    logic [ppp_pkg::DEPTH_W-1:0]    s2_dv_reg;
    logic [ppp_pkg::DOT_W-1:0]      s2_cz_reg;
    logic signed [NW-1:0]           cc_reg, hc_reg, fx_reg, fy_reg;

    logic                           s3_near_reg;
    logic [ppp_pkg::DEPTH_W-1:0]    s3_dv_reg;
    logic [ppp_pkg::DEN_W-1:0]      s3_den_reg;
    logic signed [NW-1:0]           nx_reg, ny_reg;

    div_t                           s4_reg;

    logic                           dvv_reg [STEPS+1];
    div_t                           d_reg  [STEPS+1];
    div_t                           d_next [STEPS+1];

    logic                           vis;
    logic [XW-1:0]                  px_e, py_e;

    assign en  = !out_word.valid || out_word.ready;
    assign pop = en && !qctl.empty;

    always_comb
    begin
        w_s = (int'(cfg.width)  > MAX_PANEL_PIXELS) ?
              PW'(MAX_PANEL_PIXELS) : PW'(cfg.width);
        h_s = (int'(cfg.height) > MAX_PANEL_PIXELS) ?
              PW'(MAX_PANEL_PIXELS) : PW'(cfg.height);
        l_s = (int'(cfg.left)   > MAX_PANEL_PIXELS) ?
              PW'(MAX_PANEL_PIXELS) : PW'(cfg.left);
        c_s = {1'b0, l_s, 1'b0} + CW'(w_s);
    end

    always_comb
    begin
        if (|s0_reg.cz[ppp_pkg::DOT_W-1:ppp_pkg::AXIS_FRAC+ppp_pkg::DEPTH_W])
            s1_dv_next = '1;
        else
            s1_dv_next = s0_reg.cz[ppp_pkg::AXIS_FRAC +: ppp_pkg::DEPTH_W];
    end

    always_comb
    begin
        d_next[0]     = s4_reg;
        d_next[0].ovx = ((NW'(s4_reg.den) << STEPS) <= s4_reg.rx);
        d_next[0].ovy = ((NW'(s4_reg.den) << STEPS) <= s4_reg.ry);
        for (int k = 0; k < STEPS; k++)
        begin
            d_next[k+1] = d_reg[k];
            if ((NW'(d_reg[k].den) << (STEPS-1-k)) <= d_reg[k].rx)
            begin
                d_next[k+1].rx = d_reg[k].rx - (NW'(d_reg[k].den) << (STEPS-1-k));
                d_next[k+1].qx[STEPS-1-k] = 1'b1;
            end
            if ((NW'(d_reg[k].den) << (STEPS-1-k)) <= d_reg[k].ry)
            begin
                d_next[k+1].ry = d_reg[k].ry - (NW'(d_reg[k].den) << (STEPS-1-k));
                d_next[k+1].qy[STEPS-1-k] = 1'b1;
            end
        end
    end

    always_comb
    begin
        px_e = XW'(d_reg[STEPS].qx);
        py_e = XW'(d_reg[STEPS].qy);
        vis  = d_reg[STEPS].near_ok && !d_reg[STEPS].ovx && !d_reg[STEPS].ovy
            && !(d_reg[STEPS].sx && (d_reg[STEPS].qx != '0))
            && !(d_reg[STEPS].sy && (d_reg[STEPS].qy != '0))
            && !d_reg[STEPS].qy[ppp_pkg::Q_W-1]
            && (px_e >= XW'(l_s)) && (px_e < (XW'(l_s) + XW'(w_s)))
            && (py_e < XW'(h_s));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                v_reg[i] <= 1'b0;
            for (int i = 0; i <= STEPS; i++)
                dvv_reg[i] <= 1'b0;
            out_word.valid <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= pop;
            for (int i = 1; i < 5; i++)
                v_reg[i] <= v_reg[i-1];
            dvv_reg[0] <= v_reg[4];
            for (int i = 1; i <= STEPS; i++)
                dvv_reg[i] <= dvv_reg[i-1];
            out_word.valid <= dvv_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= pop_word;

            s1_near_reg <= s0_reg.near_ok;
            s1_dv_reg   <= s1_dv_next;
            s1_cz_reg   <= s0_reg.cz;
            ccl_reg <= ppp_pkg::PART_W'(c_s * s0_reg.cz[19:0]);
            cch_reg <= ppp_pkg::PART_W'(c_s * s0_reg.cz[39:20]);
            hcl_reg <= ppp_pkg::PART_W'(h_s * s0_reg.cz[19:0]);
            hch_reg <= ppp_pkg::PART_W'(h_s * s0_reg.cz[39:20]);
            fxl_reg <= ppp_pkg::PART_W'($signed({1'b0, cfg.focal})
                       * $signed({1'b0, s0_reg.xl[19:0]}));
            fxh_reg <= ppp_pkg::PART_W'($signed({1'b0, cfg.focal})
                       * $signed(s0_reg.xl[39:20]));
            fyl_reg <= ppp_pkg::PART_W'($signed({1'b0, cfg.focal})
                       * $signed({1'b0, s0_reg.yl[19:0]}));
            fyh_reg <= ppp_pkg::PART_W'($signed({1'b0, cfg.focal})
                       * $signed(s0_reg.yl[39:20]));

            s2_near_reg <= s1_near_reg;
            s2_dv_reg   <= s1_dv_reg;
            s2_cz_reg   <= s1_cz_reg;
            cc_reg <= $signed((NW'(cch_reg) << 20) + NW'(ccl_reg));
            hc_reg <= $signed((NW'(hch_reg) << 20) + NW'(hcl_reg));
            fx_reg <= (NW'(fxh_reg) <<< 20) + $signed(NW'(fxl_reg));
            fy_reg <= (NW'(fyh_reg) <<< 20) + $signed(NW'(fyl_reg));

            s3_near_reg <= s2_near_reg;
            s3_dv_reg   <= s2_dv_reg;
            s3_den_reg  <= {s2_cz_reg, 5'd0} ;
            nx_reg <= (cc_reg <<< 4) + (fx_reg <<< 1);
            ny_reg <= (hc_reg <<< 4) - (fy_reg <<< 1);

            s4_reg.near_ok <= s3_near_reg;
            s4_reg.dv      <= s3_dv_reg;
            s4_reg.den     <= s3_den_reg;
            s4_reg.sx      <= nx_reg[NW-1];
            s4_reg.sy      <= ny_reg[NW-1];
            s4_reg.ovx     <= 1'b0;
            s4_reg.ovy     <= 1'b0;
            s4_reg.rx      <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
            s4_reg.ry      <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
            s4_reg.qx      <= '0;
            s4_reg.qy      <= '0;

            for (int i = 0; i <= STEPS; i++)
                d_reg[i] <= d_next[i];

            out_word.visible     <= vis;
            out_word.pixel_x     <= vis ? d_reg[STEPS].qx : '0;
            out_word.pixel_y     <= vis ? d_reg[STEPS].qy[ppp_pkg::PIXY_W-1:0] : '0;
            out_word.depth_value <= vis ? d_reg[STEPS].dv : '0;
        end
    end

endmodule
